/* sv/irlcf_pkg.sv */
`default_nettype none

package irlcf_pkg;

  // Longest frame a single header beat can produce.
  localparam int unsigned FrameMax = 12;
  localparam int unsigned CountW   = $clog2(FrameMax + 1);
  localparam int unsigned IdxW     = $clog2(FrameMax);

  // Frame constants.
  localparam logic [7:0] MAGIC_0      = 8'h48;
  localparam logic [7:0] MAGIC_1      = 8'h75;
  localparam logic [7:0] MAGIC_2      = 8'h30;
  localparam logic [7:0] UPLOAD_PREP  = 8'h2E;
  localparam logic [7:0] UPLOAD_END   = 8'h00;
  localparam logic [7:0] HISTORY_SIZE = 8'h2E;
  localparam logic [7:0] RAW_BIAS     = 8'h05;
  localparam logic [7:0] EMPTY_SUM    = 8'h00;

  // Command codes.
  localparam logic [7:0] CMD_SESSION = 8'h00;
  localparam logic [7:0] CMD_ICON    = 8'h02;
  localparam logic [7:0] CMD_SEARCH  = 8'h03;
  localparam logic [7:0] CMD_UPLOAD  = 8'h04;
  localparam logic [7:0] CMD_READ    = 8'h08;
  localparam logic [7:0] CMD_SEND    = 8'h0A;
  localparam logic [7:0] CMD_WRITE   = 8'h0B;

  // Item kinds.
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_FILE_SIZE  = 2'd0;
  localparam logic [1:0] REG_TITLE_ICON = 2'd1;
  localparam logic [1:0] REG_FILE_FLAGS = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [7:0]  cmd;
    logic [15:0] near_addr;
    logic [15:0] far_addr;
    logic [7:0]  length;
    logic [7:0]  param;
    logic [7:0]  slot;
    logic        upload_start;
    logic        no_payload;
    logic [7:0]  data_byte;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_end;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  reg_idx;
    logic [15:0] wdata;
  } cfg_item_t;

  // Bytes produced by one item, first byte at index 0.
  typedef struct packed {
    logic [FrameMax-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
    logic                     fend;
  } frame_t;

endpackage

`default_nettype wire

/* sv/irlcf_chan_if.sv */
`default_nettype none

interface irlcf_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/ir_link_command_framer.sv */
// Channel   Role    Payload        Beat taken when
// in_ch     sink    in_item_t      in_ch.valid && in_ch.ready
// out_ch    source  out_item_t     out_ch.valid && out_ch.ready
// cfg_ch    sink    cfg_item_t     cfg_ch.valid (ready is always high)
//
// A header beat yields 4, 11 or 12 output beats; a payload beat yields 1 or 2,
// and a stray payload beat yields none. Output runs at one beat per cycle while
// out_ch.ready is high. Input beats are taken back to back whenever the output
// keeps up; the serializer's frame buffer loads a new item when idle or as the
// held frame's last beat is taken, each item passing the input register first.
// Reset is synchronous and clears the control flags, the configuration and the
// payload state; the held input item and frame bytes are not reset.
`default_nettype none

module ir_link_command_framer (
  input  wire logic   clk,
  input  wire logic   rst_n,
  irlcf_chan_if.sink   in_ch,
  irlcf_chan_if.source out_ch,
  irlcf_chan_if.sink   cfg_ch
);

  irlcf_pkg::in_item_t in_item_r;
  logic                in_valid_r;
  irlcf_pkg::frame_t   frame;
  logic                free;
  logic                advance;

  assign advance     = in_valid_r && free;
  assign in_ch.ready = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r <= in_ch.data;
    end
  end

  irlcf_build u_build (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (in_item_r),
    .fire   (advance),
    .cfg_we (cfg_ch.valid),
    .cfg    (cfg_ch.data),
    .frame  (frame)
  );

  irlcf_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame     (frame),
    .load_req  (advance),
    .free      (free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

  // The end of a frame is always the end of the item's run.
  a_fend_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.frame_end |-> out_ch.data.run_end)
    else $error("frame_end without run_end");

  // A finished run with nothing new loaded leaves the output empty.
  a_run_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.data.run_end && !advance |=> !out_ch.valid)
    else $error("output still valid after last beat of run");

  // A held input item blocks the input while the serializer is busy.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !free |=> in_valid_r && $stable(in_item_r))
    else $error("held input item lost");

endmodule

`default_nettype wire

/* sv/irlcf_build.sv */
`default_nettype none

module irlcf_build (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire irlcf_pkg::in_item_t item,
  input  wire logic                fire,
  input  wire logic                cfg_we,
  input  wire irlcf_pkg::cfg_item_t cfg,
  output irlcf_pkg::frame_t        frame
);

  logic [15:0] file_size_r;
  logic [7:0]  title_icon_size_r;
  logic [7:0]  file_flags_r;
  logic [7:0]  data_sum_r, data_sum_nxt;
  logic        awaiting_r, awaiting_nxt;

  logic [7:0]  f0, f1, f2, f3, f4, f5;
  logic [7:0]  hsum;
  logic [7:0]  psum;
  logic [15:0] sub;
  logic [15:0] raw;
  logic        known;
  logic        has_data;

  // Raw size for the file search command, wrapping mod 65536.
  assign sub = 16'({8'h00, title_icon_size_r}) + 16'({8'h00, irlcf_pkg::RAW_BIAS})
             + (file_flags_r[0] ? 16'({8'h00, irlcf_pkg::HISTORY_SIZE}) : 16'h0000);
  assign raw = file_size_r - sub;

  // Running payload sum including the current byte.
  assign psum = data_sum_r + item.data_byte;

  // Header field selection by command.
  always_comb begin
    f0       = item.near_addr[7:0];
    f1       = item.near_addr[15:8];
    f2       = item.far_addr[7:0];
    f3       = item.far_addr[15:8];
    f4       = item.length;
    f5       = item.param;
    known    = 1'b1;
    has_data = 1'b0;
    unique case (item.cmd) inside
      irlcf_pkg::CMD_SESSION, irlcf_pkg::CMD_READ: begin
      end
      irlcf_pkg::CMD_ICON, irlcf_pkg::CMD_SEND, irlcf_pkg::CMD_WRITE: begin
        has_data = 1'b1;
      end
      irlcf_pkg::CMD_UPLOAD: begin
        f4 = item.upload_start ? irlcf_pkg::UPLOAD_PREP : irlcf_pkg::UPLOAD_END;
      end
      irlcf_pkg::CMD_SEARCH: begin
        f2       = raw[7:0];
        f3       = raw[15:8];
        f4       = item.slot;
        has_data = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign hsum = irlcf_pkg::MAGIC_2 + item.cmd + f0 + f1 + f2 + f3 + f4 + f5;

  // Frame contents and next state.
  always_comb begin
    frame        = '0;
    data_sum_nxt = data_sum_r;
    awaiting_nxt = awaiting_r;
    if (item.kind == irlcf_pkg::KIND_PAYLOAD) begin
      if (awaiting_r) begin
        data_sum_nxt   = psum;
        frame.bytes[0] = item.data_byte;
        frame.bytes[1] = 8'(~psum + 8'd1);
        if (item.last) begin
          frame.count  = irlcf_pkg::CountW'(2);
          frame.fend   = 1'b1;
          awaiting_nxt = 1'b0;
        end else begin
          frame.count = irlcf_pkg::CountW'(1);
        end
      end
    end else begin
      data_sum_nxt    = 8'h00;
      awaiting_nxt    = known && has_data && !item.no_payload;
      frame.bytes[0]  = irlcf_pkg::MAGIC_0;
      frame.bytes[1]  = irlcf_pkg::MAGIC_1;
      frame.bytes[2]  = irlcf_pkg::MAGIC_2;
      frame.bytes[3]  = item.cmd;
      frame.bytes[4]  = f0;
      frame.bytes[5]  = f1;
      frame.bytes[6]  = f2;
      frame.bytes[7]  = f3;
      frame.bytes[8]  = f4;
      frame.bytes[9]  = f5;
      frame.bytes[10] = 8'(~hsum + 8'd1);
      frame.bytes[11] = irlcf_pkg::EMPTY_SUM;
      if (!known) begin
        frame.count = irlcf_pkg::CountW'(4);
        frame.fend  = 1'b1;
      end else if (has_data && item.no_payload) begin
        frame.count = irlcf_pkg::CountW'(12);
        frame.fend  = 1'b1;
      end else begin
        frame.count = irlcf_pkg::CountW'(11);
        frame.fend  = !has_data;
      end
    end
  end

  // Configuration registers and payload state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r       <= '0;
      title_icon_size_r <= '0;
      file_flags_r      <= '0;
      data_sum_r        <= '0;
      awaiting_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg.reg_idx)
          irlcf_pkg::REG_FILE_SIZE:  file_size_r       <= cfg.wdata;
          irlcf_pkg::REG_TITLE_ICON: title_icon_size_r <= cfg.wdata[7:0];
          irlcf_pkg::REG_FILE_FLAGS: file_flags_r      <= cfg.wdata[7:0];
          default: begin
          end
        endcase
      end
      if (fire) begin
        data_sum_r <= data_sum_nxt;
        awaiting_r <= awaiting_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/irlcf_serial.sv */
`default_nettype none

module irlcf_serial (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire irlcf_pkg::frame_t frame,
  input  wire logic              load_req,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output irlcf_pkg::out_item_t   out_data
);

  irlcf_pkg::frame_t            buf_r;
  logic                         busy_r;
  logic [irlcf_pkg::IdxW-1:0]   idx_r;
  logic                         at_last;
  logic                         load;

  assign at_last = (idx_r == irlcf_pkg::IdxW'(buf_r.count - irlcf_pkg::CountW'(1)));
  assign free    = !busy_r || (out_ready && at_last);
  assign load    = load_req && free && (frame.count != '0);

  // Current beat of the held frame.
  assign out_valid           = busy_r;
  assign out_data.byte_value = buf_r.bytes[idx_r];
  assign out_data.frame_end  = at_last && buf_r.fend;
  assign out_data.run_end    = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r && out_ready) begin
        if (at_last) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + irlcf_pkg::IdxW'(1);
        end
      end
    end
  end

  // Frame bytes are payload: no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= frame;
    end
  end

endmodule

`default_nettype wire
